// ===== src/mecanum_odometry_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the mecanum odometry block
// Concurrent assertion wrappers, compiled out under synthesis.
// ---------------------------------------------------------------------------
`ifndef MECANUM_ODOMETRY_TOP_DEFINES_SVH
`define MECANUM_ODOMETRY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MO_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MO_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MO_ASSERT(label, clk, rst_n, prop, msg)
`define MO_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== src/mo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Mecanum odometry package
// Shared types, constants and command structs.
// ---------------------------------------------------------------------------
package mo_pkg;
  localparam int FracBits = 16;
  localparam int CordicSteps = 16;
  localparam int StepW = 5;
  localparam int HeadW = 19;

  localparam logic [1:0] OP_VEL = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ZERO = 2'd2;

  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] PI_F = 34'sd205887;
  localparam logic signed [33:0] TWO_PI_F = 34'sd411774;
  // floor(2^RecipShift / TWO_PI_F), estimate of the turn count
  localparam logic [31:0] TWO_PI_RECIP = 32'd2734266628;
  localparam int RecipShift = 50;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VSUM, ST_VMUL, ST_YDIV, ST_HDIV, ST_HMOD, ST_HWRAP, ST_CORDIC,
    ST_RMUL, ST_RSUM, ST_PDIVX, ST_PDIVY, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic vsum;
    logic vmul;
    logic div_start;
    logic [1:0] div_sel;
    logic hmod;
    logic hwrap;
    logic cord_init;
    logic cord_step;
    logic rmul;
    logic rsum;
    logic zero_pose;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic [1:0] op;
    logic cord_last;
  } sts_t;

  function automatic logic [33:0] atan_q30(input logic [StepW-1:0] i);
    case (i)
      5'd0: atan_q30 = 34'd843314857;
      5'd1: atan_q30 = 34'd497837829;
      5'd2: atan_q30 = 34'd263043837;
      5'd3: atan_q30 = 34'd133525159;
      5'd4: atan_q30 = 34'd67021687;
      5'd5: atan_q30 = 34'd33543516;
      5'd6: atan_q30 = 34'd16775851;
      5'd7: atan_q30 = 34'd8388437;
      5'd8: atan_q30 = 34'd4194283;
      5'd9: atan_q30 = 34'd2097149;
      default: atan_q30 = 34'd1048576 >> (i - 5'd10);
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== src/mecanum_odometry_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Mecanum odometry top level
// Four-wheel mecanum velocity and dead-reckoning pose in Q16.16.
// ---------------------------------------------------------------------------
// One item at a time: an operation 0 item runs the 67-step radix-2 divider
// once, an operation 1 item runs it three times plus 16 CORDIC steps, and
// operation 2 or 3 items use neither.
// The result register frees the input side as soon as a result is stored.
module mecanum_odometry_top
  import mo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  // operation[1:0], speed_left_front, speed_left_back, speed_right_front,
  // speed_right_back, zero pad to 136 bits
  input  wire logic [135:0] in_tdata,
  output logic out_tvalid,
  input  wire logic out_tready,
  // velocity_x, velocity_y, yaw_rate, position_x, position_y, heading[18:0],
  // zero pad to 184 bits
  output logic [183:0] out_tdata,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [3:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic [23:0] hl_r, hwd_r, wr_r;
  logic [7:0] tr_r;
  cmd_t cmd;
  sts_t sts;
  logic in_fire, out_fire, ov, res_load;
  logic signed [31:0] vx, vy, yw, px, py;
  logic signed [HeadW-1:0] hd;
  logic [183:0] od_r;

  assign cfg_pready = 1'b1;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r <= 24'd13107; hwd_r <= 24'd13107; wr_r <= 24'd3277; tr_r <= 8'd100;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        4'h0: hl_r <= cfg_pwdata[23:0];
        4'h4: hwd_r <= cfg_pwdata[23:0];
        4'h8: wr_r <= cfg_pwdata[23:0];
        4'hc: tr_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      4'h0: cfg_prdata = {8'd0, hl_r};
      4'h4: cfg_prdata = {8'd0, hwd_r};
      4'h8: cfg_prdata = {8'd0, wr_r};
      4'hc: cfg_prdata = {24'd0, tr_r};
      default: cfg_prdata = '0;
    endcase
  end

  mo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .in_ready(in_tready), .out_valid(ov),
    .res_load(res_load)
  );

  mo_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .op(in_tdata[1:0]),
    .lf(in_tdata[33:2]), .lb(in_tdata[65:34]), .rf(in_tdata[97:66]),
    .rb(in_tdata[129:98]), .half_length(hl_r), .half_width(hwd_r),
    .wheel_radius(wr_r), .tick_rate(tr_r), .vel_x(vx), .vel_y(vy), .yaw(yw),
    .pos_x(px), .pos_y(py), .head(hd)
  );

  always_ff @(posedge clk) begin
    if (res_load) od_r <= {5'd0, hd, py, px, yw, vy, vx};
  end

  assign out_tvalid = ov;
  assign out_tdata = od_r;
endmodule
`default_nettype wire

// ===== src/mo_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Radix-2 divider
// Signed numerator over unsigned divisor, nearest rounding, ties away from 0.
// ---------------------------------------------------------------------------
module mo_divider
  import mo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [66:0] num,
  input  wire logic [35:0] den,
  output logic busy,
  output logic signed [66:0] quo
);
  logic [66:0] rem_r, rem_nxt, q_r, q_nxt;
  logic [35:0] d_r;
  logic neg_r;
  logic [6:0] cnt_r;
  logic [67:0] trial;
  logic [66:0] mag;

  assign mag = num[66] ? 67'(-num) + 67'(den >> 1) : num + 67'(den >> 1);
  assign trial = {rem_r, q_r[66]} - 68'(d_r);
  assign busy = cnt_r != 7'd0;
  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);

  always_comb begin
    rem_nxt = trial[67] ? {rem_r[65:0], q_r[66]} : trial[66:0];
    q_nxt = {q_r[65:0], ~trial[67]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 7'd0;
    end else if (start) begin
      cnt_r <= 7'd67;
      rem_r <= '0;
      q_r <= mag;
      d_r <= den;
      neg_r <= num[66];
    end else if (busy) begin
      cnt_r <= cnt_r - 7'd1;
      rem_r <= rem_nxt;
      q_r <= q_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/mo_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Mecanum odometry datapath
// Kinematic sums, shared divider, CORDIC and pose registers.
// ---------------------------------------------------------------------------
module mo_datapath
  import mo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  output sts_t sts,
  input  wire logic [1:0] op,
  input  wire logic signed [31:0] lf, lb, rf, rb,
  input  wire logic [23:0] half_length, half_width, wheel_radius,
  input  wire logic [7:0] tick_rate,
  output logic signed [31:0] vel_x, vel_y, yaw, pos_x, pos_y,
  output logic signed [HeadW-1:0] head
);
  logic [1:0] op_r;
  logic signed [31:0] lf_r, lb_r, rf_r, rb_r;
  logic signed [33:0] sx_r, sy_r, sw_r;
  logic signed [58:0] pw_r;
  logic signed [31:0] vx_r, vy_r, yw_r, posx_r, posy_r, hd_r;
  logic signed [33:0] h_r, cx_r, cy_r, cz_r;
  logic flip_r;
  logic [StepW-1:0] k_r;
  logic signed [65:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [66:0] dx_r, dy_r;
  logic signed [66:0] div_num;
  logic [35:0] div_den;
  logic signed [66:0] quo;
  logic div_busy;
  logic signed [33:0] c_s, s_s, xs, ys, hw, zf;
  logic signed [33:0] zq;
  logic [35:0] base, rate;
  logic signed [15:0] hq_r;
  logic signed [66:0] hprod;
  logic signed [33:0] hm;

  assign base = {10'd0, 26'(half_length) + 26'(half_width)} << 2;
  assign rate = (tick_rate == 8'd0) ? 36'd1 : 36'(tick_rate);
  assign c_s = flip_r ? -cx_r : cx_r;
  assign s_s = flip_r ? -cy_r : cy_r;
  assign xs = cx_r >>> k_r;
  assign ys = cy_r >>> k_r;

  function automatic logic signed [31:0] sat(input logic signed [66:0] v);
    if (v > 67'sd2147483647) sat = 32'sh7fffffff;
    else if (v < -67'sd2147483648) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  always_comb begin
    case (cmd.div_sel)
      2'd0: begin div_num = 67'(pw_r); div_den = base; end
      2'd1: begin div_num = 67'(yw_r); div_den = rate; end
      2'd2: begin div_num = dx_r; div_den = rate; end
      default: begin div_num = dy_r; div_den = rate; end
    endcase
  end

  mo_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(div_num),
    .den(div_den), .busy(div_busy), .quo(quo)
  );

  assign hw = h_r + PI_F;
  assign hprod = hw * $signed({1'b0, TWO_PI_RECIP});
  assign hm = hw - 34'(hq_r) * TWO_PI_F;
  assign zf = (hm >= TWO_PI_F) ? hm - TWO_PI_F : (hm < 0 ? hm + TWO_PI_F : hm);
  assign zq = 34'(hd_r) <<< (30 - FracBits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= '0; vy_r <= '0; yw_r <= '0;
      posx_r <= '0; posy_r <= '0; hd_r <= '0;
    end else begin
      if (cmd.load) begin
        op_r <= op; lf_r <= lf; lb_r <= lb; rf_r <= rf; rb_r <= rb;
      end
      if (cmd.vsum) begin
        sx_r <= 34'(lf_r) + 34'(rf_r) + 34'(lb_r) + 34'(rb_r);
        sy_r <= -34'(lf_r) + 34'(rf_r) + 34'(lb_r) - 34'(rb_r);
        sw_r <= -34'(lf_r) + 34'(rf_r) - 34'(lb_r) + 34'(rb_r);
      end
      if (cmd.vmul) begin
        pw_r <= sw_r * $signed({1'b0, wheel_radius});
        vx_r <= sat(67'(((sx_r * $signed({1'b0, wheel_radius}))
                + (59'sd1 <<< (FracBits + 1))) >>> (FracBits + 2)));
        vy_r <= sat(67'(((sy_r * $signed({1'b0, wheel_radius}))
                + (59'sd1 <<< (FracBits + 1))) >>> (FracBits + 2)));
      end
      if (cmd.div_start && cmd.div_sel == 2'd1) h_r <= 34'(hd_r);
      if (cmd.hmod) hq_r <= 16'(hprod >>> RecipShift);
      if (!div_busy && cmd.hwrap) hd_r <= 32'(zf - PI_F);
      if (cmd.cord_init) begin
        cx_r <= GAIN_Q30; cy_r <= '0; k_r <= '0;
        if (zq > HALF_PI_Q30) begin cz_r <= zq - PI_Q30; flip_r <= 1'b1; end
        else if (zq < -HALF_PI_Q30) begin cz_r <= zq + PI_Q30; flip_r <= 1'b1; end
        else begin cz_r <= zq; flip_r <= 1'b0; end
      end
      if (cmd.cord_step) begin
        k_r <= k_r + 1'b1;
        if (!cz_r[33]) begin
          cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - $signed(atan_q30(k_r));
        end else begin
          cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + $signed(atan_q30(k_r));
        end
      end
      if (cmd.rmul) begin
        m1_r <= 66'(vx_r) * 66'(c_s);
        m2_r <= 66'(vy_r) * 66'(s_s);
        m3_r <= 66'(vx_r) * 66'(s_s);
        m4_r <= 66'(vy_r) * 66'(c_s);
      end
      if (cmd.rsum) begin
        dx_r <= (67'(m1_r) - 67'(m2_r) + (67'sd1 <<< 29)) >>> 30;
        dy_r <= (67'(m3_r) + 67'(m4_r) + (67'sd1 <<< 29)) >>> 30;
      end
      if (cmd.out_load) begin
        case (cmd.div_sel)
          2'd0: yw_r <= (base == 36'd0) ? 32'sd0 : sat(quo);
          2'd1: h_r <= h_r + quo[33:0];
          2'd2: posx_r <= sat(67'(posx_r) + quo);
          default: posy_r <= sat(67'(posy_r) + quo);
        endcase
      end
      if (cmd.zero_pose) begin
        posx_r <= '0; posy_r <= '0; hd_r <= '0;
      end
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.op = op_r;
  assign sts.cord_last = k_r == StepW'(CordicSteps - 1);
  assign vel_x = vx_r;
  assign vel_y = vy_r;
  assign yaw = yw_r;
  assign pos_x = posx_r;
  assign pos_y = posy_r;
  assign head = hd_r[HeadW-1:0];

  `include "mecanum_odometry_top_defines.svh"
  `MO_ASSERT(a_head_range, clk, rst_n, hd_r >= -32'sd205887 && hd_r < 32'sd205887, "heading out of range")
  `MO_ASSERT(a_div_once, clk, rst_n, cmd.div_start |=> div_busy, "divider did not start")
  `MO_ASSERT(a_cord_excl, clk, rst_n, !(cmd.cord_step && cmd.cord_init), "cordic init and step")
endmodule
`default_nettype wire

// ===== src/mo_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Mecanum odometry controller
// Sequences one item through the datapath and drives the handshakes.
// ---------------------------------------------------------------------------
module mo_ctrl
  import mo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_valid,
  output logic res_load
);
  state_t state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic entered_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_VSUM;
      ST_VSUM: begin
        unique case (sts.op)
          OP_VEL: state_nxt = ST_VMUL;
          OP_TICK: state_nxt = ST_HDIV;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_VMUL: state_nxt = ST_YDIV;
      ST_YDIV: if (entered_r && !sts.div_busy) state_nxt = ST_DONE;
      ST_HDIV: if (!sts.div_busy) state_nxt = ST_HMOD;
      ST_HMOD: state_nxt = ST_HWRAP;
      ST_HWRAP: state_nxt = ST_CORDIC;
      ST_CORDIC: if (sts.cord_last) state_nxt = ST_RMUL;
      ST_RMUL: state_nxt = ST_RSUM;
      ST_RSUM: state_nxt = ST_PDIVX;
      ST_PDIVX: if (entered_r && !sts.div_busy) state_nxt = ST_PDIVY;
      ST_PDIVY: if (entered_r && !sts.div_busy) state_nxt = ST_DONE;
      ST_DONE: if (!ov_r || out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: cmd.load = in_fire;
      ST_VSUM: begin
        cmd.vsum = 1'b1;
        cmd.zero_pose = sts.op == OP_ZERO;
        cmd.div_start = sts.op == OP_TICK;
        cmd.div_sel = 2'd1;
      end
      ST_VMUL: begin cmd.vmul = 1'b1; end
      ST_YDIV: begin
        cmd.div_sel = 2'd0;
        cmd.div_start = !entered_r;
        cmd.out_load = entered_r && !sts.div_busy;
      end
      ST_HDIV: begin
        cmd.div_sel = 2'd1;
        cmd.out_load = !sts.div_busy;
      end
      ST_HMOD: begin cmd.hmod = 1'b1; end
      ST_HWRAP: begin cmd.hwrap = 1'b1; end
      ST_CORDIC: begin
        cmd.cord_init = !entered_r;
        cmd.cord_step = entered_r;
      end
      ST_RMUL: cmd.rmul = 1'b1;
      ST_RSUM: cmd.rsum = 1'b1;
      ST_PDIVX: begin
        cmd.div_sel = 2'd2;
        cmd.div_start = !entered_r;
        cmd.out_load = entered_r && !sts.div_busy;
      end
      ST_PDIVY: begin
        cmd.div_sel = 2'd3;
        cmd.div_start = !entered_r;
        cmd.out_load = entered_r && !sts.div_busy;
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_fire) ov_nxt = 1'b0;
    if (state_r == ST_DONE && (!ov_r || out_fire)) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      entered_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      entered_r <= (state_nxt == state_r) && (state_r != ST_IDLE);
    end
  end

  assign in_ready = state_r == ST_IDLE;
  assign out_valid = ov_r;
  assign res_load = state_r == ST_DONE && (!ov_r || out_fire);

  `include "mecanum_odometry_top_defines.svh"
  `MO_ASSERT(a_one_div, clk, rst_n, cmd.div_start |-> !sts.div_busy, "divider restarted")
  `MO_ASSERT(a_idle_accept, clk, rst_n, in_fire |=> state_r == ST_VSUM, "accept lost")
  `MO_ASSERT_NR(a_rst, clk, !rst_n |=> state_r == ST_IDLE, "reset state")
endmodule
`default_nettype wire

// ===== test/mecanum_odometry_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mecanum odometry testbench
// Drives wheel-speed, tick and zero-pose items through the stream port under
// several geometry and tick-rate settings, predicts each result with a
// fixed-point kinematics and CORDIC model, and checks every result in order.
// ---------------------------------------------------------------------------
module mecanum_odometry_top_tb;
  import mo_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [3:0] ADDR_HALF_LENGTH = 4'd0;
  localparam logic [3:0] ADDR_HALF_WIDTH = 4'd4;
  localparam logic [3:0] ADDR_WHEEL_RADIUS = 4'd8;
  localparam logic [3:0] ADDR_TICK_RATE = 4'd12;
  localparam longint PI_FIX = 205887;
  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam longint HALF_PI_Q30_L = 64'sd1686629713;
  localparam longint GAIN_Q30_L = 64'sd652032874;

  typedef struct {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [18:0] head;
  } pose_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [135:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [183:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  mecanum_odometry_top dut (.*);

  // Model state
  longint half_len, half_wid, radius, rate_reg;
  longint vx_m, vy_m, yaw_m, px_m, py_m, head_m;
  pose_t pose_q[$];
  int errors;
  int n_items;
  int n_op[4];
  int stall_left;

  const longint atan_tab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint rnd_div(input longint num, input longint d);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (mag + d / 2) / d;
    return num < 0 ? -q : q;
  endfunction

  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = ang <<< (30 - FracBits);
    x = GAIN_Q30_L;
    y = 0;
    flip = 0;
    if (z > HALF_PI_Q30_L) begin
      z -= PI_Q30_L;
      flip = 1;
    end else if (z < -HALF_PI_Q30_L) begin
      z += PI_Q30_L;
      flip = 1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_tab[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic advance_odometry(input logic [1:0] op, input longint lf, input longint lb,
                                  input longint rf, input longint rb);
    longint rate, base, h, m, c, s, dx, dy;
    pose_t p;
    rate = rate_reg == 0 ? 1 : rate_reg;
    case (op)
      OP_VEL: begin
        base = 4 * (half_len + half_wid);
        vx_m = sat32(rnd_shift((lf + rf + lb + rb) * radius, FracBits + 2));
        vy_m = sat32(rnd_shift((-lf + rf + lb - rb) * radius, FracBits + 2));
        yaw_m = base == 0 ? 0 : sat32(rnd_div((-lf + rf - lb + rb) * radius, base));
      end
      OP_TICK: begin
        h = head_m + rnd_div(yaw_m, rate);
        m = (h + PI_FIX) % (2 * PI_FIX);
        if (m < 0) m += 2 * PI_FIX;
        head_m = m - PI_FIX;
        sin_cos(head_m, c, s);
        dx = rnd_shift(vx_m * c - vy_m * s, 30);
        dy = rnd_shift(vx_m * s + vy_m * c, 30);
        px_m = sat32(px_m + rnd_div(dx, rate));
        py_m = sat32(py_m + rnd_div(dy, rate));
      end
      OP_ZERO: begin
        px_m = 0;
        py_m = 0;
        head_m = 0;
      end
      default: ;
    endcase
    p.vel_x = vx_m[31:0];
    p.vel_y = vy_m[31:0];
    p.yaw = yaw_m[31:0];
    p.pos_x = px_m[31:0];
    p.pos_y = py_m[31:0];
    p.head = head_m[18:0];
    pose_q.push_back(p);
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    pose_t e;
    pose_t a;
    if (rst_n && out_tvalid && out_tready) begin
      a.vel_x = out_tdata[31:0];
      a.vel_y = out_tdata[63:32];
      a.yaw = out_tdata[95:64];
      a.pos_x = out_tdata[127:96];
      a.pos_y = out_tdata[159:128];
      a.head = out_tdata[178:160];
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_tdata);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (a.vel_x !== e.vel_x) begin
          $display("%0t: velocity_x exp %0d got %0d", $realtime, e.vel_x, a.vel_x);
          errors++;
        end
        if (a.vel_y !== e.vel_y) begin
          $display("%0t: velocity_y exp %0d got %0d", $realtime, e.vel_y, a.vel_y);
          errors++;
        end
        if (a.yaw !== e.yaw) begin
          $display("%0t: yaw_rate exp %0d got %0d", $realtime, e.yaw, a.yaw);
          errors++;
        end
        if (a.pos_x !== e.pos_x) begin
          $display("%0t: position_x exp %0d got %0d", $realtime, e.pos_x, a.pos_x);
          errors++;
        end
        if (a.pos_y !== e.pos_y) begin
          $display("%0t: position_y exp %0d got %0d", $realtime, e.pos_y, a.pos_y);
          errors++;
        end
        if (a.head !== e.head) begin
          $display("%0t: heading exp %0d got %0d", $realtime, e.head, a.head);
          errors++;
        end
      end
    end
    if (out_tready && out_tvalid) begin
      stall_left = $urandom_range(3) == 0 ? 0 : $urandom_range(19);
      out_tready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= (stall_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] lf, input logic [31:0] lb,
                           input logic [31:0] rf, input logic [31:0] rb, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    advance_odometry(op, longint'(signed'(lf)), longint'(signed'(lb)),
                     longint'(signed'(rf)), longint'(signed'(rb)));
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, rb, rf, lb, lf, op};
    do @(posedge clk); while (!in_tready);
    n_items++;
    n_op[op]++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (addr)
      ADDR_HALF_LENGTH: half_len = val[23:0];
      ADDR_HALF_WIDTH: half_wid = val[23:0];
      ADDR_WHEEL_RADIUS: radius = val[23:0];
      ADDR_TICK_RATE: rate_reg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [31:0] lx, input logic [31:0] ly,
                              input logic [31:0] r, input logic [31:0] rate);
    drain();
    write_reg(ADDR_HALF_LENGTH, lx);
    write_reg(ADDR_HALF_WIDTH, ly);
    write_reg(ADDR_WHEEL_RADIUS, r);
    write_reg(ADDR_TICK_RATE, rate);
  endtask

  function automatic logic [31:0] pick_speed;
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'(signed'($urandom_range(2000000)) - 1000000);
      default: return 32'(signed'($urandom_range(1310720)) - 655360);
    endcase
  endfunction

  task automatic test_directed;
    send_item(OP_TICK, 0, 0, 0, 0, 0);
    send_item(OP_VEL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 2);
    send_item(OP_VEL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 0);
    send_item(OP_VEL, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1);
    send_item(OP_TICK, 0, 0, 0, 0, 0);
    send_item(OP_VEL, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
    repeat (6) send_item(OP_TICK, 0, 0, 0, 0, 0);
    send_item(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
    send_item(OP_ZERO, 32'h12345678, 0, 0, 0, 3);
    send_item(OP_VEL, 32'h00010000, 32'hffff0000, 32'h00010000, 32'hffff0000, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 0);
    send_item(OP_VEL, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 0);
    send_item(OP_ZERO, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int count);
    logic [1:0] op;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(19);
      op = r < 6 ? OP_VEL : r < 17 ? OP_TICK : r < 19 ? OP_ZERO : OP_NONE;
      send_item(op, pick_speed(), pick_speed(), pick_speed(), pick_speed(),
                $urandom_range(2) == 0 ? 0 : $urandom_range(19));
      if (i == count / 2) begin
        in_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_settings;
    test_random(110);
    set_geometry(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    test_random(100);
    set_geometry(1, 1, 1, 1);
    test_random(100);
    set_geometry(0, 0, 32'h00ffffff, 0);
    test_random(100);
    set_geometry(32'h00001000, 32'h00002000, 32'h00020000, 32'd7);
    test_random(100);
    set_geometry($urandom, $urandom, $urandom, $urandom_range(255));
    test_random(100);
    set_geometry(13107, 13107, 3277, 100);
    test_random(110);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    stall_left = 0;
    errors = 0;
    n_items = 0;
    n_op = '{0, 0, 0, 0};
    half_len = 13107;
    half_wid = 13107;
    radius = 3277;
    rate_reg = 100;
    vx_m = 0;
    vy_m = 0;
    yaw_m = 0;
    px_m = 0;
    py_m = 0;
    head_m = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    drain();
    $display("%0d items: %0d velocity, %0d tick, %0d zero, %0d unused, seven settings",
             n_items, n_op[0], n_op[1], n_op[2], n_op[3]);
    if (errors == 0) begin
      $display("mecanum_odometry_top_tb passed");
    end else begin
      $display("mecanum_odometry_top_tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("mecanum_odometry_top_tb failed");
    $finish;
  end
endmodule
